/* sv/cpt_pkg.sv */
package cpt_pkg;

	// Field widths.
	localparam int ANGLE_BITS = 16;
	localparam int DATA_BITS  = 16;

	// Quarter-wave sine table: SINE_DEPTH+1 unsigned Q1.16 words, the last one is 1.0.
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_W     = 17;
	localparam int IDX_W      = $clog2(SINE_DEPTH + 1);

	// Request type codes.
	localparam logic REQ_FORWARD = 1'b0;
	localparam logic REQ_INVERSE = 1'b1;

	// Q2.16 coefficients, rounded to nearest.
	localparam logic signed [17:0] K_INV_SQRT3     = 18'sd37837;
	localparam logic signed [17:0] K_TWO_INV_SQRT3 = 18'sd75674;
	localparam logic signed [17:0] K_SQRT3_HALF    = 18'sd56756;
	localparam logic signed [17:0] RND_HALF        = 18'sd32768;
	localparam int                 FRAC_BITS       = 16;

	// pi/2 in Q2.30, used only while building the sine table.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q16     = 64'd65536;

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH+1];

	// Builds the table once at elaboration: a Taylor series to x^15 in Q2.30 with each
	// term truncated, then rounded half up to Q1.16 and capped at 1.0.
	function automatic sine_rom_t sine_rom_build();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] r;
		longint      acc;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x    = (64'(i) * HALF_PI_Q30) / 64'(SINE_DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			r = (64'(acc) + 64'd8192) >> 14;
			if (r > ONE_Q16) begin
				r = ONE_Q16;
			end
			rom[i] = SINE_W'(r);
		end
		return rom;
	endfunction

endpackage

/* sv/cpt_req_if.sv */
interface cpt_req_if import cpt_pkg::*; ();

	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [ANGLE_BITS-1:0]       angle;
	logic signed [DATA_BITS-1:0] in_first;
	logic signed [DATA_BITS-1:0] in_second;

	modport source (output valid, output req_type, output angle, output in_first,
		output in_second, input ready);
	modport sink (input valid, input req_type, input angle, input in_first,
		input in_second, output ready);

endinterface

/* sv/cpt_rsp_if.sv */
interface cpt_rsp_if import cpt_pkg::*; ();

	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] out_first;
	logic signed [DATA_BITS-1:0] out_second;
	logic                        saturated;

	modport source (output valid, output out_first, output out_second, output saturated,
		input ready);
	modport sink (input valid, input out_first, input out_second, input saturated,
		output ready);

endinterface

/* sv/clarke_park_transform.sv */
// Channel  Dir  Beat contents
// -------  ---  ----------------------------------------------------------
// req      in   req_type, angle, in_first, in_second (phases a/b or d/q)
// rsp      out  out_first, out_second (d/q or phases a/b), saturated
//
// Six register stages; a beat accepted on req passes through stages 1 to 6 and leaves
// on rsp from the stage 6 register; one beat can enter every cycle while rsp is not stalled.
// Reset (arst_n low) clears only the stage valid bits, so the pipeline comes up empty.
// Each stage holds its beat while the stage after it is full and stalled; an empty
// stage always loads, so bubbles fill even while the output register waits.
// The throughput is set by the per-stage handshake alone; no stage iterates.
module clarke_park_transform import cpt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cpt_req_if.sink   req,
	cpt_rsp_if.source rsp
);

	// Working widths. Alpha/beta need two guard bits above the data range, the rotated
	// values three; products carry the 18-bit signed coefficient on top.
	localparam int W_AB   = DATA_BITS + 2;
	localparam int W_PA   = DATA_BITS + 18;
	localparam int W_PY   = W_PA + 1;
	localparam int W_ROT  = 18 + W_AB;
	localparam int W_RS   = W_ROT + 1;
	localparam int W_R    = DATA_BITS + 3;
	localparam int W_M    = W_R + 18;
	localparam int W_MS   = W_M + 1;
	localparam int W_X    = ANGLE_BITS - 1;
	localparam int W_IP   = W_X + IDX_W;
	localparam int QSHIFT = ANGLE_BITS - 2;

	localparam logic [W_X-1:0] QUARTER = W_X'(64'd1 << QSHIFT);
	localparam logic signed [W_R-1:0] SAT_HI = W_R'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
	localparam logic signed [W_R-1:0] SAT_LO = -SAT_HI - W_R'(1);

	localparam sine_rom_t SineRom = sine_rom_build();

	// Stage handshake: stage k loads when it is empty or when stage k+1 loads.
	logic [5:0] stage_en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_comb begin
		stage_en[5] = !vld_s6 || rsp.ready;
		stage_en[4] = !vld_s5 || stage_en[5];
		stage_en[3] = !vld_s4 || stage_en[4];
		stage_en[2] = !vld_s3 || stage_en[3];
		stage_en[1] = !vld_s2 || stage_en[2];
		stage_en[0] = !vld_s1 || stage_en[1];
	end

	assign req.ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (stage_en[0]) vld_s1 <= req.valid;
			if (stage_en[1]) vld_s2 <= vld_s1;
			if (stage_en[2]) vld_s3 <= vld_s2;
			if (stage_en[3]) vld_s4 <= vld_s3;
			if (stage_en[4]) vld_s5 <= vld_s4;
			if (stage_en[5]) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: table addresses for sine and cosine, and the two Clarke products.
	// Cosine is the sine of the next quadrant with the same in-quadrant offset.
	logic [1:0]     quad_s;
	logic [1:0]     quad_c;
	logic [W_X-1:0] offs;
	logic [W_X-1:0] x_sin;
	logic [W_X-1:0] x_cos;
	logic [W_IP-1:0] ip_sin;
	logic [W_IP-1:0] ip_cos;

	always_comb begin
		quad_s = req.angle[ANGLE_BITS-1 -: 2];
		quad_c = quad_s + 2'd1;
		offs   = W_X'(req.angle[QSHIFT-1:0]);
		x_sin  = quad_s[0] ? (QUARTER - offs) : offs;
		x_cos  = quad_c[0] ? (QUARTER - offs) : offs;
		ip_sin = W_IP'(x_sin) * W_IP'(SINE_DEPTH);
		ip_cos = W_IP'(x_cos) * W_IP'(SINE_DEPTH);
	end

	logic                        type_s1;
	logic [IDX_W-1:0]            idx_sin_s1;
	logic [IDX_W-1:0]            idx_cos_s1;
	logic                        neg_sin_s1;
	logic                        neg_cos_s1;
	logic signed [DATA_BITS-1:0] first_s1;
	logic signed [DATA_BITS-1:0] second_s1;
	logic signed [W_PA-1:0]      pa_s1;
	logic signed [W_PA-1:0]      pb_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			type_s1    <= req.req_type;
			idx_sin_s1 <= ip_sin[QSHIFT +: IDX_W];
			idx_cos_s1 <= ip_cos[QSHIFT +: IDX_W];
			neg_sin_s1 <= quad_s[1];
			neg_cos_s1 <= quad_c[1];
			first_s1   <= req.in_first;
			second_s1  <= req.in_second;
			pa_s1      <= W_PA'(req.in_first) * W_PA'(K_INV_SQRT3);
			pb_s1      <= W_PA'(req.in_second) * W_PA'(K_TWO_INV_SQRT3);
		end
	end

	// Stage 2: registered table reads; beta of the forward path is rounded here.
	logic signed [W_PY-1:0] y_sum;
	logic signed [W_PY-1:0] y_rnd;

	always_comb begin
		y_sum = W_PY'(pa_s1) + W_PY'(pb_s1);
		y_rnd = (y_sum + W_PY'(RND_HALF)) >>> FRAC_BITS;
	end

	logic                    type_s2;
	logic [SINE_W-1:0]       sin_mag_s2;
	logic [SINE_W-1:0]       cos_mag_s2;
	logic                    neg_sin_s2;
	logic                    neg_cos_s2;
	logic signed [W_AB-1:0]  u_s2;
	logic signed [W_AB-1:0]  v_s2;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			type_s2    <= type_s1;
			sin_mag_s2 <= SineRom[idx_sin_s1];
			cos_mag_s2 <= SineRom[idx_cos_s1];
			neg_sin_s2 <= neg_sin_s1;
			neg_cos_s2 <= neg_cos_s1;
			u_s2       <= W_AB'(first_s1);
			v_s2       <= (type_s1 == REQ_INVERSE) ? W_AB'(second_s1) : W_AB'(y_rnd);
		end
	end

	// Stage 3: signed sine and cosine, and the four rotation products.
	logic signed [17:0] sin_v;
	logic signed [17:0] cos_v;

	always_comb begin
		sin_v = $signed({1'b0, sin_mag_s2});
		cos_v = $signed({1'b0, cos_mag_s2});
		if (neg_sin_s2) sin_v = -sin_v;
		if (neg_cos_s2) cos_v = -cos_v;
	end

	logic                    type_s3;
	logic signed [W_ROT-1:0] cu_s3;
	logic signed [W_ROT-1:0] sv_s3;
	logic signed [W_ROT-1:0] cv_s3;
	logic signed [W_ROT-1:0] su_s3;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			type_s3 <= type_s2;
			cu_s3   <= W_ROT'(cos_v) * W_ROT'(u_s2);
			sv_s3   <= W_ROT'(sin_v) * W_ROT'(v_s2);
			cv_s3   <= W_ROT'(cos_v) * W_ROT'(v_s2);
			su_s3   <= W_ROT'(sin_v) * W_ROT'(u_s2);
		end
	end

	// Stage 4: the forward rotation (Park) or the inverse rotation, then rounding.
	logic signed [W_RS-1:0] rot1;
	logic signed [W_RS-1:0] rot2;
	logic signed [W_RS-1:0] rot1_r;
	logic signed [W_RS-1:0] rot2_r;

	always_comb begin
		if (type_s3 == REQ_INVERSE) begin
			rot1 = W_RS'(cu_s3) - W_RS'(sv_s3);
			rot2 = W_RS'(su_s3) + W_RS'(cv_s3);
		end else begin
			rot1 = W_RS'(cu_s3) + W_RS'(sv_s3);
			rot2 = W_RS'(cv_s3) - W_RS'(su_s3);
		end
		rot1_r = (rot1 + W_RS'(RND_HALF)) >>> FRAC_BITS;
		rot2_r = (rot2 + W_RS'(RND_HALF)) >>> FRAC_BITS;
	end

	logic                  type_s4;
	logic signed [W_R-1:0] r1_s4;
	logic signed [W_R-1:0] r2_s4;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			type_s4 <= type_s3;
			r1_s4   <= W_R'(rot1_r);
			r2_s4   <= W_R'(rot2_r);
		end
	end

	// Stage 5: inverse Clarke terms for phase b. The forward path feeds its q value
	// through as q * 2^16, which the common rounding below returns unchanged.
	logic signed [W_R-1:0] a_s5;
	logic signed [W_M-1:0] ta_s5;
	logic signed [W_M-1:0] tb_s5;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			a_s5 <= r1_s4;
			if (type_s4 == REQ_INVERSE) begin
				ta_s5 <= -(W_M'(r1_s4) <<< (FRAC_BITS - 1));
				tb_s5 <= W_M'(r2_s4) * W_M'(K_SQRT3_HALF);
			end else begin
				ta_s5 <= W_M'(r2_s4) <<< FRAC_BITS;
				tb_s5 <= '0;
			end
		end
	end

	// Stage 6: final rounding, saturation to the data range, output register.
	logic signed [W_MS-1:0] b_sum;
	logic signed [W_MS-1:0] b_rnd;
	logic signed [W_R-1:0]  b_val;
	logic signed [DATA_BITS-1:0] o1;
	logic signed [DATA_BITS-1:0] o2;
	logic clip1;
	logic clip2;

	always_comb begin
		b_sum = W_MS'(ta_s5) + W_MS'(tb_s5);
		b_rnd = (b_sum + W_MS'(RND_HALF)) >>> FRAC_BITS;
		b_val = W_R'(b_rnd);
		clip1 = 1'b1;
		clip2 = 1'b1;
		if (a_s5 > SAT_HI) begin
			o1 = DATA_BITS'(SAT_HI);
		end else if (a_s5 < SAT_LO) begin
			o1 = DATA_BITS'(SAT_LO);
		end else begin
			o1    = DATA_BITS'(a_s5);
			clip1 = 1'b0;
		end
		if (b_val > SAT_HI) begin
			o2 = DATA_BITS'(SAT_HI);
		end else if (b_val < SAT_LO) begin
			o2 = DATA_BITS'(SAT_LO);
		end else begin
			o2    = DATA_BITS'(b_val);
			clip2 = 1'b0;
		end
	end

	logic signed [DATA_BITS-1:0] out_first_s6;
	logic signed [DATA_BITS-1:0] out_second_s6;
	logic                        saturated_s6;

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			out_first_s6  <= o1;
			out_second_s6 <= o2;
			saturated_s6  <= clip1 || clip2;
		end
	end

	assign rsp.valid      = vld_s6;
	assign rsp.out_first  = out_first_s6;
	assign rsp.out_second = out_second_s6;
	assign rsp.saturated  = saturated_s6;

`ifndef SYNTHESIS
	// An accepted request beat always occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s1)
		else $error("accepted request beat did not enter stage 1");

	// A full stage whose successor is stalled keeps its beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !stage_en[5] |=> vld_s5 && vld_s6)
		else $error("stage 5 beat lost while output stalled");

	// A full stage whose successor is stalled keeps its beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !stage_en[2] |=> vld_s2 && vld_s3)
		else $error("stage 2 beat lost while stage 3 stalled");

	// A clipped result has at least one output pinned at a range limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.saturated |->
			(rsp.out_first == DATA_BITS'(SAT_HI)) || (rsp.out_first == DATA_BITS'(SAT_LO)) ||
			(rsp.out_second == DATA_BITS'(SAT_HI)) || (rsp.out_second == DATA_BITS'(SAT_LO)))
		else $error("saturated flag set without an output at a limit");
`endif

endmodule

/* test/clarke_park_transform_tb.sv */
module clarke_park_transform_tb import cpt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Coefficients in Q2.16 and pi/2 in Q2.30. The testbench keeps its own copy
	// so that a wrong constant in the design does not cancel out in the check.
	localparam longint          COEF_INV_SQRT3     = 37837;
	localparam longint          COEF_TWO_INV_SQRT3 = 75674;
	localparam longint          COEF_SQRT3_HALF    = 56756;
	localparam longint          COEF_HALF          = 32768;
	localparam longint unsigned QUARTER_PI2_Q30    = 64'd1686629713;
	localparam longint unsigned UNIT_Q16           = 64'd65536;

	// Number of random beats in each random phase.
	localparam int RANDOM_PER_PHASE = 350;
	localparam int DIRECTED_ROWS    = 20;

	// One request beat as the sender drives it.
	typedef struct packed {
		logic                        req_type;
		logic [ANGLE_BITS-1:0]       angle;
		logic signed [DATA_BITS-1:0] in_first;
		logic signed [DATA_BITS-1:0] in_second;
	} req_beat_t;

	// One response beat as it should come out of the block.
	typedef struct packed {
		logic signed [DATA_BITS-1:0] out_first;
		logic signed [DATA_BITS-1:0] out_second;
		logic                        saturated;
	} transform_out_t;

	// A row of the directed table. Where typed is set, the expected response is
	// the one written in the row; otherwise it comes from the predictor.
	typedef struct packed {
		req_beat_t      beat;
		logic           typed;
		transform_out_t want;
	} stim_row_t;

	localparam logic signed [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
	localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

	// Angle landmarks: an eighth, a quarter, half and three quarters of a turn.
	localparam logic [ANGLE_BITS-1:0] ANG_Q1 = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] ANG_Q2 = ANGLE_BITS'(2) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] ANG_Q3 = ANGLE_BITS'(3) << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-1:0] ANG_EIGHTH = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

	logic clk;
	logic arst_n;

	cpt_req_if req_ch ();
	cpt_rsp_if rsp_ch ();

	clarke_park_transform dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Quarter-wave sine words in Q1.16, filled once before reset is released.
	logic [16:0] quarter_sine [0:SINE_DEPTH];

	// Responses still owed by the block, oldest first.
	transform_out_t expected_outs [$];
	transform_out_t oldest_out;
	int             mismatches;

	// Idling controls, changed by the stimulus process between phases and within them.
	int send_idle_pct;
	int stall_pct;

	// The directed table. At angle zero the cosine word is exactly one and the
	// sine word zero, so those rows can be read off by hand: forward gives
	// d = a and q = beta, inverse gives a = d and b = -d/2. The remaining rows
	// cover quadrant edges, the last angle code and the wide alpha/beta path.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{REQ_FORWARD, ANGLE_BITS'(0), DATA_BITS'(0), DATA_BITS'(0)}, 1'b1,
			'{DATA_BITS'(0), DATA_BITS'(0), 1'b0}},
		'{'{REQ_INVERSE, ANGLE_BITS'(0), DATA_BITS'(0), DATA_BITS'(0)}, 1'b1,
			'{DATA_BITS'(0), DATA_BITS'(0), 1'b0}},
		'{'{REQ_FORWARD, ANGLE_BITS'(0), DATA_MAX, DATA_MAX}, 1'b1,
			'{DATA_MAX, DATA_MAX, 1'b1}},
		'{'{REQ_FORWARD, ANGLE_BITS'(0), DATA_MIN, DATA_MIN}, 1'b1,
			'{DATA_MIN, DATA_MIN, 1'b1}},
		'{'{REQ_INVERSE, ANGLE_BITS'(0), DATA_MAX, DATA_BITS'(0)}, 1'b1,
			'{DATA_MAX, -DATA_BITS'(16383), 1'b0}},
		'{'{REQ_INVERSE, ANGLE_BITS'(0), DATA_MIN, DATA_BITS'(0)}, 1'b1,
			'{DATA_MIN, DATA_BITS'(16384), 1'b0}},
		'{'{REQ_FORWARD, ANGLE_BITS'(0), DATA_MAX, DATA_BITS'(0)}, 1'b0, '0},
		'{'{REQ_FORWARD, ANG_Q1, DATA_MIN, DATA_BITS'(0)}, 1'b0, '0},
		'{'{REQ_FORWARD, ANG_Q2, DATA_MAX, DATA_MIN}, 1'b0, '0},
		'{'{REQ_FORWARD, ANG_Q3, DATA_MIN, DATA_MAX}, 1'b0, '0},
		'{'{REQ_FORWARD, '1, DATA_MAX, DATA_MAX}, 1'b0, '0},
		'{'{REQ_FORWARD, ANGLE_BITS'(1), DATA_BITS'(1), -DATA_BITS'(1)}, 1'b0, '0},
		'{'{REQ_FORWARD, ANG_EIGHTH, DATA_MAX, DATA_MIN}, 1'b0, '0},
		'{'{REQ_INVERSE, ANG_Q1, DATA_MAX, DATA_MAX}, 1'b0, '0},
		'{'{REQ_INVERSE, ANG_Q2, DATA_MIN, DATA_MAX}, 1'b0, '0},
		'{'{REQ_INVERSE, ANG_Q3, DATA_MAX, DATA_MIN}, 1'b0, '0},
		'{'{REQ_INVERSE, '1, DATA_MIN, DATA_MIN}, 1'b0, '0},
		// Rotating full-scale d and q by an eighth turn pushes beta well past
		// the data range; it must survive until the inverse Clarke stage.
		'{'{REQ_INVERSE, ANG_EIGHTH, DATA_MAX, DATA_MAX}, 1'b0, '0},
		'{'{REQ_INVERSE, ANG_EIGHTH, DATA_MIN, DATA_MIN}, 1'b0, '0},
		'{'{REQ_INVERSE, ANG_Q1 + ANG_EIGHTH, DATA_MAX, DATA_MIN}, 1'b0, '0}
	};

	// Table word i: sin(pi/2 * i / depth) by a Taylor series in Q2.30 with every
	// term truncated, then rounded half up to Q1.16 and capped at one.
	function automatic longint unsigned quarter_sine_word(int i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned den;
		longint unsigned r;
		longint          acc;
		x    = (longint'(i) * QUARTER_PI2_Q30) / longint'(SINE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			den  = (2 * k) * (2 * k + 1);
			term = ((term * x2) >> 30) / den;
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = (longint'(acc) + 64'd8192) >> 14;
		if (r > UNIT_Q16) begin
			r = UNIT_Q16;
		end
		return r;
	endfunction

	// Signed sine of an angle: the quadrant picks the table direction and sign.
	function automatic longint sine_at(logic [ANGLE_BITS-1:0] ang);
		longint unsigned qt;
		longint unsigned p;
		longint unsigned x;
		longint unsigned idx;
		logic [1:0]      quad;
		longint          v;
		qt   = 64'd1 << (ANGLE_BITS - 2);
		quad = ang[ANGLE_BITS-1 -: 2];
		p    = longint'(ang[ANGLE_BITS-3:0]);
		x    = quad[0] ? qt - p : p;
		idx  = (x * longint'(SINE_DEPTH)) >> (ANGLE_BITS - 2);
		if (idx > SINE_DEPTH) begin
			idx = SINE_DEPTH;
		end
		v = longint'(quarter_sine[idx]);
		return quad[1] ? -v : v;
	endfunction

	// Scale by 2^-16 with rounding half up.
	function automatic longint scale_round(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clip_data(longint v, inout logic clipped);
		if (v > longint'(DATA_MAX)) begin
			clipped = 1'b1;
			return longint'(DATA_MAX);
		end
		if (v < longint'(DATA_MIN)) begin
			clipped = 1'b1;
			return longint'(DATA_MIN);
		end
		return v;
	endfunction

	// Expected response of one beat: Clarke then Park, or inverse Park then
	// inverse Clarke, with alpha/beta held at full width.
	function automatic transform_out_t transform_predict(req_beat_t b);
		longint                s;
		longint                c;
		longint                f;
		longint                g;
		longint                x;
		longint                y;
		longint                o1;
		longint                o2;
		logic                  clipped;
		logic [ANGLE_BITS-1:0] ang_cos;
		transform_out_t        r;
		clipped = 1'b0;
		f       = longint'(b.in_first);
		g       = longint'(b.in_second);
		ang_cos = b.angle + ANG_Q1;
		s       = sine_at(b.angle);
		c       = sine_at(ang_cos);
		if (b.req_type == REQ_FORWARD) begin
			x  = f;
			y  = scale_round(COEF_INV_SQRT3 * f + COEF_TWO_INV_SQRT3 * g);
			o1 = clip_data(scale_round(c * x + s * y), clipped);
			o2 = clip_data(scale_round(c * y - s * x), clipped);
		end else begin
			x  = scale_round(c * f - s * g);
			y  = scale_round(s * f + c * g);
			o1 = clip_data(x, clipped);
			o2 = clip_data(scale_round(-COEF_HALF * x + COEF_SQRT3_HALF * y), clipped);
		end
		r.out_first  = DATA_BITS'(o1);
		r.out_second = DATA_BITS'(o2);
		r.saturated  = clipped;
		return r;
	endfunction

	// Random sample: mostly full range, with extremes and values near zero
	// weighted up so that rounding and clipping edges are hit often.
	function automatic logic signed [DATA_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return DATA_MAX;
			end
			1: begin
				return DATA_MIN;
			end
			2: begin
				return DATA_BITS'(int'($urandom_range(0, 16)) - 8);
			end
			default: begin
				return DATA_BITS'($urandom);
			end
		endcase
	endfunction

	// Random angle: mostly anywhere on the turn, sometimes a few codes either
	// side of a quadrant edge where the table direction flips.
	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		logic [ANGLE_BITS-1:0] edge_ang;
		if ($urandom_range(0, 4) == 0) begin
			edge_ang = ANGLE_BITS'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
			return edge_ang + ANGLE_BITS'(int'($urandom_range(0, 6)) - 3);
		end
		return ANGLE_BITS'($urandom);
	endfunction

	// Drives one request beat, with random idle cycles in front of it, and
	// records its expected response at the edge where it is accepted. Inputs
	// change only at the falling edge; ready is sampled at the rising edge.
	task automatic drive_beat(input req_beat_t b, input logic typed, input transform_out_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid     = 1'b1;
		req_ch.req_type  = b.req_type;
		req_ch.angle     = b.angle;
		req_ch.in_first  = b.in_first;
		req_ch.in_second = b.in_second;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		expected_outs.push_back(typed ? want : transform_predict(b));
		@(negedge clk);
	endtask

	// Lets the pipeline drain: the sender holds off until every response owed
	// has come back, so the next phase starts on an empty block.
	task automatic drain_outputs();
		req_ch.valid = 1'b0;
		while (expected_outs.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The receiver stalls at random, re-decided at every falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Response checker: every accepted beat is matched against the oldest
	// expectation, field by field. A beat with nothing owed is an error too.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_outs.size() == 0) begin
				mismatches++;
				$display("%0t: response beat with none expected: %0d %0d %0b", $realtime,
					rsp_ch.out_first, rsp_ch.out_second, rsp_ch.saturated);
			end else begin
				oldest_out = expected_outs.pop_front();
				if (rsp_ch.out_first !== oldest_out.out_first) begin
					mismatches++;
					$display("%0t: out_first expected %0d, got %0d", $realtime,
						oldest_out.out_first, rsp_ch.out_first);
				end
				if (rsp_ch.out_second !== oldest_out.out_second) begin
					mismatches++;
					$display("%0t: out_second expected %0d, got %0d", $realtime,
						oldest_out.out_second, rsp_ch.out_second);
				end
				if (rsp_ch.saturated !== oldest_out.saturated) begin
					mismatches++;
					$display("%0t: saturated expected %0b, got %0b", $realtime,
						oldest_out.saturated, rsp_ch.saturated);
				end
			end
		end
	end

	// Stimulus: directed table first, then four phases of random beats with
	// different idling on each side. Each phase ends with a full drain.
	initial begin
		req_beat_t beat;
		arst_n           = 1'b0;
		mismatches       = 0;
		send_idle_pct    = 0;
		stall_pct        = 0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_FORWARD;
		req_ch.angle     = '0;
		req_ch.in_first  = '0;
		req_ch.in_second = '0;
		rsp_ch.ready     = 1'b0;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			quarter_sine[i] = 17'(quarter_sine_word(i));
		end
		repeat (2) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			drive_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 86;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 86;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct     = 17;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				beat.req_type  = logic'($urandom_range(0, 1));
				beat.angle     = pick_angle();
				beat.in_first  = pick_sample();
				beat.in_second = pick_sample();
				drive_beat(beat, 1'b0, '0);
				// Bursts with no sender idling at all, inside the idling phases.
				if (phase != 0 && n % 100 == 50) begin
					send_idle_pct = 0;
				end else if (phase == 1 && n % 100 == 80) begin
					send_idle_pct = 86;
				end else if (phase == 3 && n % 100 == 80) begin
					send_idle_pct = 17;
				end
			end
			drain_outputs();
		end

		// Everything is back; give the six-stage pipeline time to show any
		// stray beat before the verdict.
		stall_pct = 0;
		repeat (16) begin
			@(posedge clk);
		end
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog. The slowest correct run is well under a quarter of a millisecond.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
